// ----- hdl/vbqt_pkg.sv -----
// ----------------------------------------------------------------------------
// vbqt_pkg
// Shared types, constants and the oriented check table of the tessellator.
// ----------------------------------------------------------------------------
package vbqt_pkg;

  localparam int MAX_DIM    = 256;
  localparam int DIM_BITS   = $clog2(MAX_DIM);
  localparam int PLANE_BITS = 4;                      // bank * 6 + direction
  localparam int SLOT_DEPTH = 12 * MAX_DIM * MAX_DIM;
  localparam int SLOT_AW    = $clog2(SLOT_DEPTH);

  localparam int COORD_W  = 9;
  localparam int LABEL_W  = 8;
  localparam int VTX_W    = 24;
  localparam int FACE_W   = 25;
  localparam int CFG_W    = 25;
  localparam int CFG_IDX_W = 3;

  localparam int NUM_CHECKS = 24;
  localparam int Q_BITS     = $clog2(NUM_CHECKS);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LABEL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALL_LABELS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VOL_WIDTH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VOL_HEIGHT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VOL_DEPTH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VERTICES = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FACES    = 3'd6;

  localparam logic [LABEL_W-1:0] RST_TARGET_LABEL = 8'd255;
  localparam logic [COORD_W-1:0] RST_DIM          = 9'd256;
  localparam logic [VTX_W-1:0]   RST_MAX_VERTICES = 24'd10000000;
  localparam logic [FACE_W-1:0]  RST_MAX_FACES    = 25'd20000000;

  // record kinds and error codes
  localparam logic [1:0] REC_VERTEX = 2'd0;
  localparam logic [1:0] REC_FACE   = 2'd1;
  localparam logic [1:0] REC_ERROR  = 2'd2;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_VTX  = 2'd1;
  localparam logic [1:0] ERR_FACE = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_READ
  } state_t;

  typedef enum logic [2:0] {
    SEL_VERTEX,
    SEL_FACE_NEW,
    SEL_FACE_READ,
    SEL_ERR_STORED,
    SEL_ERR_VTX,
    SEL_ERR_FACE
  } out_sel_t;

  typedef struct packed {
    logic     capture;
    logic     load_out;
    out_sel_t out_sel;
    logic     vtx_inc;
    logic     face_inc;
    logic     mem_we;
    logic     mem_re;
    logic     q_clear;
    logic     q_inc;
    logic     bank_toggle;
    logic     set_stop_vtx;
    logic     set_stop_face;
  } cmd_t;

  typedef struct packed {
    logic stopped;
    logic mask_empty;
    logic vtx_ovf;
    logic face_ovf;
    logic fire;
    logic corner0;
    logic q_last;
    logic end_slice;
    logic out_free;
  } status_t;

  // voxel code: bit2 current slice, bit1 row (not row-1), bit0 col (not col-1)
  typedef struct packed {
    logic [2:0] a;
    logic [2:0] b;
    logic [2:0] dir;
    logic [1:0] corner;
  } check_t;

  function automatic check_t check_entry(input logic [Q_BITS-1:0] q);
    check_t ck;
    case (q)
      5'd0:  ck = '{3'd4, 3'd0, 3'd0, 2'd2};
      5'd1:  ck = '{3'd5, 3'd1, 3'd0, 2'd3};
      5'd2:  ck = '{3'd7, 3'd3, 3'd0, 2'd0};
      5'd3:  ck = '{3'd6, 3'd2, 3'd0, 2'd1};
      5'd4:  ck = '{3'd2, 3'd0, 3'd2, 2'd2};
      5'd5:  ck = '{3'd3, 3'd1, 3'd2, 2'd1};
      5'd6:  ck = '{3'd7, 3'd5, 3'd2, 2'd0};
      5'd7:  ck = '{3'd6, 3'd4, 3'd2, 2'd3};
      5'd8:  ck = '{3'd1, 3'd0, 3'd4, 2'd2};
      5'd9:  ck = '{3'd3, 3'd2, 3'd4, 2'd3};
      5'd10: ck = '{3'd7, 3'd6, 3'd4, 2'd0};
      5'd11: ck = '{3'd5, 3'd4, 3'd4, 2'd1};
      5'd12: ck = '{3'd0, 3'd4, 3'd1, 2'd2};
      5'd13: ck = '{3'd1, 3'd5, 3'd1, 2'd1};
      5'd14: ck = '{3'd3, 3'd7, 3'd1, 2'd0};
      5'd15: ck = '{3'd2, 3'd6, 3'd1, 2'd3};
      5'd16: ck = '{3'd0, 3'd2, 3'd3, 2'd2};
      5'd17: ck = '{3'd1, 3'd3, 3'd3, 2'd3};
      5'd18: ck = '{3'd5, 3'd7, 3'd3, 2'd0};
      5'd19: ck = '{3'd4, 3'd6, 3'd3, 2'd1};
      5'd20: ck = '{3'd0, 3'd1, 3'd5, 2'd2};
      5'd21: ck = '{3'd2, 3'd3, 3'd5, 2'd1};
      5'd22: ck = '{3'd6, 3'd7, 3'd5, 2'd0};
      5'd23: ck = '{3'd4, 3'd5, 3'd5, 2'd3};
      default: ck = '{3'd0, 3'd0, 3'd0, 2'd0};
    endcase
    return ck;
  endfunction

endpackage

// ----- hdl/vbqt_ram.sv -----
// ----------------------------------------------------------------------------
// vbqt_ram
// Generic single-port RAM with registered read data (held when not reading).
// ----------------------------------------------------------------------------
module vbqt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ----- hdl/vbqt_ctrl.sv -----
// ----------------------------------------------------------------------------
// vbqt_ctrl
// Sequencer: vertex decision, one oriented check per step, slot reads.
// ----------------------------------------------------------------------------
module vbqt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  vbqt_pkg::status_t status,
  output vbqt_pkg::cmd_t    cmd
);

  vbqt_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vbqt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      vbqt_pkg::ST_IDLE: begin
        if (in_valid) state_next = vbqt_pkg::ST_START;
      end
      vbqt_pkg::ST_START: begin
        if (status.stopped) begin
          if (status.out_free) state_next = vbqt_pkg::ST_IDLE;
        end else if (status.mask_empty) begin
          state_next = vbqt_pkg::ST_IDLE;
        end else if (status.out_free) begin
          state_next = status.vtx_ovf ? vbqt_pkg::ST_IDLE : vbqt_pkg::ST_SCAN;
        end
      end
      vbqt_pkg::ST_SCAN: begin
        if (!status.fire) begin
          if (status.q_last) state_next = vbqt_pkg::ST_IDLE;
        end else if (status.corner0) begin
          if (status.out_free && (status.face_ovf || status.q_last)) begin
            state_next = vbqt_pkg::ST_IDLE;
          end
        end else begin
          state_next = vbqt_pkg::ST_READ;
        end
      end
      vbqt_pkg::ST_READ: begin
        if (status.out_free) begin
          state_next = status.q_last ? vbqt_pkg::ST_IDLE : vbqt_pkg::ST_SCAN;
        end
      end
      default: state_next = vbqt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.out_sel = vbqt_pkg::SEL_VERTEX;
    in_stall = 1'b1;
    case (state)
      vbqt_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.capture = in_valid;
      end
      vbqt_pkg::ST_START: begin
        if (status.stopped) begin
          cmd.load_out = status.out_free;
          cmd.out_sel  = vbqt_pkg::SEL_ERR_STORED;
        end else if (status.mask_empty) begin
          cmd.bank_toggle = status.end_slice;
        end else if (status.vtx_ovf) begin
          cmd.load_out     = status.out_free;
          cmd.out_sel      = vbqt_pkg::SEL_ERR_VTX;
          cmd.set_stop_vtx = status.out_free;
        end else begin
          cmd.load_out = status.out_free;
          cmd.vtx_inc  = status.out_free;
          cmd.q_clear  = status.out_free;
        end
      end
      vbqt_pkg::ST_SCAN: begin
        if (!status.fire) begin
          cmd.q_inc       = !status.q_last;
          cmd.bank_toggle = status.q_last && status.end_slice;
        end else if (status.corner0) begin
          if (status.face_ovf) begin
            cmd.load_out      = status.out_free;
            cmd.out_sel       = vbqt_pkg::SEL_ERR_FACE;
            cmd.set_stop_face = status.out_free;
          end else begin
            cmd.load_out    = status.out_free;
            cmd.out_sel     = vbqt_pkg::SEL_FACE_NEW;
            cmd.mem_we      = status.out_free;
            cmd.face_inc    = status.out_free;
            cmd.q_inc       = status.out_free && !status.q_last;
            cmd.bank_toggle = status.out_free && status.q_last && status.end_slice;
          end
        end else begin
          cmd.mem_re = 1'b1;
        end
      end
      vbqt_pkg::ST_READ: begin
        cmd.load_out    = status.out_free;
        cmd.out_sel     = vbqt_pkg::SEL_FACE_READ;
        cmd.q_inc       = status.out_free && !status.q_last;
        cmd.bank_toggle = status.out_free && status.q_last && status.end_slice;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- hdl/vbqt_dp.sv -----
// ----------------------------------------------------------------------------
// vbqt_dp
// Datapath: configuration, boundary mask, counters, slot table, result register.
// ----------------------------------------------------------------------------
module vbqt_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [vbqt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vbqt_pkg::CFG_W-1:0]          cfg_data,
  input  logic [vbqt_pkg::COORD_W-1:0]        slice,
  input  logic [vbqt_pkg::COORD_W-1:0]        row,
  input  logic [vbqt_pkg::COORD_W-1:0]        col,
  input  logic [8*vbqt_pkg::LABEL_W-1:0]      labels,
  input  vbqt_pkg::cmd_t                      cmd,
  output vbqt_pkg::status_t                   status,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          record_kind,
  output logic [vbqt_pkg::VTX_W-1:0]          vertex_number,
  output logic [vbqt_pkg::FACE_W-1:0]         face_number,
  output logic [1:0]                          corner_slot,
  output logic                                opens_face,
  output logic [2:0]                          face_direction,
  output logic [1:0]                          error_code,
  output logic                                last_of_run
);

  localparam int CW = vbqt_pkg::COORD_W;

  logic [vbqt_pkg::LABEL_W-1:0] target_label;
  logic                         all_labels;
  logic [CW-1:0]                vol_width, vol_height, vol_depth;
  logic [vbqt_pkg::VTX_W-1:0]   vtx_limit;
  logic [vbqt_pkg::FACE_W-1:0]  max_faces;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_label <= vbqt_pkg::RST_TARGET_LABEL;
      all_labels   <= 1'b0;
      vol_width    <= vbqt_pkg::RST_DIM;
      vol_height   <= vbqt_pkg::RST_DIM;
      vol_depth    <= vbqt_pkg::RST_DIM;
      vtx_limit    <= vbqt_pkg::RST_MAX_VERTICES;
      max_faces    <= vbqt_pkg::RST_MAX_FACES;
    end else if (cfg_write) begin
      case (cfg_index)
        vbqt_pkg::CFG_TARGET_LABEL: target_label <= cfg_data[vbqt_pkg::LABEL_W-1:0];
        vbqt_pkg::CFG_ALL_LABELS:   all_labels   <= cfg_data[0];
        vbqt_pkg::CFG_VOL_WIDTH:    vol_width    <= cfg_data[CW-1:0];
        vbqt_pkg::CFG_VOL_HEIGHT:   vol_height   <= cfg_data[CW-1:0];
        vbqt_pkg::CFG_VOL_DEPTH:    vol_depth    <= cfg_data[CW-1:0];
        vbqt_pkg::CFG_MAX_VERTICES: vtx_limit    <= cfg_data[vbqt_pkg::VTX_W-1:0];
        vbqt_pkg::CFG_MAX_FACES:    max_faces    <= cfg_data[vbqt_pkg::FACE_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp dimensions to the table size
  logic [CW-1:0] w_eff, h_eff, d_eff;
  assign w_eff = (vol_width  > CW'(vbqt_pkg::MAX_DIM)) ? CW'(vbqt_pkg::MAX_DIM) : vol_width;
  assign h_eff = (vol_height > CW'(vbqt_pkg::MAX_DIM)) ? CW'(vbqt_pkg::MAX_DIM) : vol_height;
  assign d_eff = (vol_depth  > CW'(vbqt_pkg::MAX_DIM)) ? CW'(vbqt_pkg::MAX_DIM) : vol_depth;

  // voxel at coord-1+hi lies in [0, dim)
  function automatic logic axis_in(input logic [CW-1:0] coord, input logic hi,
                                   input logic [CW-1:0] dim);
    logic res;
    res = hi ? (coord < dim) : ((coord != '0) && (coord <= dim));
    return res;
  endfunction

  logic [7:0]                    inb;
  logic [vbqt_pkg::NUM_CHECKS-1:0] mask_in;

  always_comb begin
    vbqt_pkg::check_t ck;
    logic [vbqt_pkg::LABEL_W-1:0] la, lb;
    for (int v = 0; v < 8; v++) begin
      inb[v] = axis_in(slice, v[2], d_eff) && axis_in(row, v[1], h_eff)
               && axis_in(col, v[0], w_eff);
    end
    for (int q = 0; q < vbqt_pkg::NUM_CHECKS; q++) begin
      ck = vbqt_pkg::check_entry(vbqt_pkg::Q_BITS'(q));
      la = labels[ck.a*vbqt_pkg::LABEL_W +: vbqt_pkg::LABEL_W];
      lb = labels[ck.b*vbqt_pkg::LABEL_W +: vbqt_pkg::LABEL_W];
      mask_in[q] = inb[ck.a] && inb[ck.b] &&
                   ((all_labels && (la != lb)) ||
                    ((la == target_label) && (lb != target_label)));
    end
  end

  // per-corner work registers
  logic [CW-1:0]                   row_q, col_q;
  logic [vbqt_pkg::NUM_CHECKS-1:0] mask;
  logic                            end_slice;
  logic [vbqt_pkg::Q_BITS-1:0]     q_idx;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      row_q     <= row;
      col_q     <= col;
      mask      <= mask_in;
      end_slice <= (row == h_eff) && (col == w_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_idx <= '0;
    end else if (cmd.q_clear) begin
      q_idx <= '0;
    end else if (cmd.q_inc) begin
      q_idx <= q_idx + 1'b1;
    end
  end

  // counters and stop state
  logic                       bank_select;
  logic [vbqt_pkg::VTX_W-1:0]  vertex_count, cur_vertex;
  logic [vbqt_pkg::FACE_W-1:0] face_count;
  logic [1:0]                  stop_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_select  <= 1'b0;
      vertex_count <= '0;
      face_count   <= '0;
      stop_code    <= vbqt_pkg::ERR_NONE;
    end else begin
      if (cmd.bank_toggle)   bank_select  <= ~bank_select;
      if (cmd.vtx_inc)       vertex_count <= vertex_count + 1'b1;
      if (cmd.face_inc)      face_count   <= face_count + 1'b1;
      if (cmd.set_stop_vtx)  stop_code    <= vbqt_pkg::ERR_VTX;
      if (cmd.set_stop_face) stop_code    <= vbqt_pkg::ERR_FACE;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.vtx_inc) cur_vertex <= vertex_count;
  end

  // slot table address for the current check
  vbqt_pkg::check_t                 ck_cur;
  logic                             bank;
  logic [vbqt_pkg::PLANE_BITS-1:0]  plane;
  logic [CW-1:0]                    i_sum, j_sum;
  logic [vbqt_pkg::SLOT_AW-1:0]     addr;
  logic [vbqt_pkg::FACE_W-1:0]      rdata;

  assign ck_cur = vbqt_pkg::check_entry(q_idx);
  assign bank   = ck_cur.a[2] ? ~bank_select : bank_select;
  assign plane  = (bank ? vbqt_pkg::PLANE_BITS'(6) : vbqt_pkg::PLANE_BITS'(0))
                  + vbqt_pkg::PLANE_BITS'(ck_cur.dir);
  assign i_sum  = row_q + CW'(ck_cur.a[1]) - CW'(1);
  assign j_sum  = col_q + CW'(ck_cur.a[0]) - CW'(1);
  assign addr   = {plane, i_sum[vbqt_pkg::DIM_BITS-1:0], j_sum[vbqt_pkg::DIM_BITS-1:0]};

  vbqt_ram #(
    .WIDTH (vbqt_pkg::FACE_W),
    .DEPTH (vbqt_pkg::SLOT_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (cmd.mem_we),
    .re    (cmd.mem_re),
    .addr  (addr),
    .wdata (face_count),
    .rdata (rdata)
  );

  // status
  logic out_free;
  assign out_free = !out_valid || !out_stall;

  assign status.stopped    = (stop_code != vbqt_pkg::ERR_NONE);
  assign status.mask_empty = ~|mask;
  assign status.vtx_ovf    = (25'(vertex_count) + 25'd1) >= 25'(vtx_limit);
  assign status.face_ovf   = (26'(face_count) + 26'd1) >= 26'(max_faces);
  assign status.fire       = mask[q_idx];
  assign status.corner0    = (ck_cur.corner == 2'd0);
  assign status.q_last     = (q_idx == vbqt_pkg::Q_BITS'(vbqt_pkg::NUM_CHECKS - 1));
  assign status.end_slice  = end_slice;
  assign status.out_free   = out_free;

  logic face_last;
  assign face_last = ~|((mask >> q_idx) >> 1);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  logic [1:0]                  kind_next, slot_next, err_next;
  logic [vbqt_pkg::VTX_W-1:0]  vn_next;
  logic [vbqt_pkg::FACE_W-1:0] fn_next;
  logic                        opens_next, last_next;
  logic [2:0]                  dir_next;

  always_comb begin
    kind_next  = vbqt_pkg::REC_ERROR;
    vn_next    = '0;
    fn_next    = '0;
    slot_next  = 2'd0;
    opens_next = 1'b0;
    dir_next   = 3'd0;
    err_next   = vbqt_pkg::ERR_NONE;
    last_next  = 1'b1;
    case (cmd.out_sel)
      vbqt_pkg::SEL_VERTEX: begin
        kind_next = vbqt_pkg::REC_VERTEX;
        vn_next   = vertex_count;
        last_next = ~|mask;
      end
      vbqt_pkg::SEL_FACE_NEW: begin
        kind_next  = vbqt_pkg::REC_FACE;
        vn_next    = cur_vertex;
        fn_next    = face_count;
        opens_next = 1'b1;
        dir_next   = ck_cur.dir;
        last_next  = face_last;
      end
      vbqt_pkg::SEL_FACE_READ: begin
        kind_next = vbqt_pkg::REC_FACE;
        vn_next   = cur_vertex;
        fn_next   = rdata;
        slot_next = ck_cur.corner;
        dir_next  = ck_cur.dir;
        last_next = face_last;
      end
      vbqt_pkg::SEL_ERR_STORED: err_next = stop_code;
      vbqt_pkg::SEL_ERR_VTX:    err_next = vbqt_pkg::ERR_VTX;
      vbqt_pkg::SEL_ERR_FACE:   err_next = vbqt_pkg::ERR_FACE;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      record_kind    <= kind_next;
      vertex_number  <= vn_next;
      face_number    <= fn_next;
      corner_slot    <= slot_next;
      opens_face     <= opens_next;
      face_direction <= dir_next;
      error_code     <= err_next;
      last_of_run    <= last_next;
    end
  end

endmodule

// ----- hdl/voxel_boundary_quad_tessellator.sv -----
// ----------------------------------------------------------------------------
// voxel_boundary_quad_tessellator
// Cuberille boundary extraction: vertex and quad-corner records per corner.
// ----------------------------------------------------------------------------
// An item is captured in the idle state; its first record, if any, is loaded into
// the result register from the start state once that register is free. A vertex
//   then takes one scan step per check and one read step per read of the single-port slot table.
// One item at a time; the next is taken once the last record of
//   the current one is in the result register.
// Reset: synchronous; clears counters, bank select, stop state; config to defaults.
module voxel_boundary_quad_tessellator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [vbqt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vbqt_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [vbqt_pkg::COORD_W-1:0]      slice,
  input  logic [vbqt_pkg::COORD_W-1:0]      row,
  input  logic [vbqt_pkg::COORD_W-1:0]      col,
  input  logic [vbqt_pkg::LABEL_W-1:0]      v_prev_above_left,
  input  logic [vbqt_pkg::LABEL_W-1:0]      v_prev_above_right,
  input  logic [vbqt_pkg::LABEL_W-1:0]      v_prev_below_left,
  input  logic [vbqt_pkg::LABEL_W-1:0]      v_prev_below_right,
  input  logic [vbqt_pkg::LABEL_W-1:0]      v_cur_above_left,
  input  logic [vbqt_pkg::LABEL_W-1:0]      v_cur_above_right,
  input  logic [vbqt_pkg::LABEL_W-1:0]      v_cur_below_left,
  input  logic [vbqt_pkg::LABEL_W-1:0]      v_cur_below_right,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        record_kind,
  output logic [vbqt_pkg::VTX_W-1:0]        vertex_number,
  output logic [vbqt_pkg::FACE_W-1:0]       face_number,
  output logic [1:0]                        corner_slot,
  output logic                              opens_face,
  output logic [2:0]                        face_direction,
  output logic [1:0]                        error_code,
  output logic                              last_of_run
);

  vbqt_pkg::cmd_t    cmd;
  vbqt_pkg::status_t status;
  logic [8*vbqt_pkg::LABEL_W-1:0] labels;

  // packed by voxel code: bit2 current slice, bit1 row, bit0 col
  assign labels = {v_cur_below_right, v_cur_below_left,
                   v_cur_above_right, v_cur_above_left,
                   v_prev_below_right, v_prev_below_left,
                   v_prev_above_right, v_prev_above_left};

  vbqt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  vbqt_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .slice          (slice),
    .row            (row),
    .col            (col),
    .labels         (labels),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .record_kind    (record_kind),
    .vertex_number  (vertex_number),
    .face_number    (face_number),
    .corner_slot    (corner_slot),
    .opens_face     (opens_face),
    .face_direction (face_direction),
    .error_code     (error_code),
    .last_of_run    (last_of_run)
  );

endmodule

// ----- hdl/vbqt_checker.sv -----
// ----------------------------------------------------------------------------
// vbqt_checker
// Port-level checks on the record stream of the tessellator.
// ----------------------------------------------------------------------------
module vbqt_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [1:0]                  record_kind,
  input logic [vbqt_pkg::FACE_W-1:0] face_number,
  input logic [1:0]                  corner_slot,
  input logic                        opens_face,
  input logic                        last_of_run
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(face_number) && $stable(record_kind))
    else $error("stalled record changed");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (record_kind == vbqt_pkg::REC_ERROR) |-> last_of_run)
    else $error("error record not last of run");

  a_open: assert property (@(posedge clk) disable iff (rst)
    out_valid && opens_face |-> (record_kind == vbqt_pkg::REC_FACE) && (corner_slot == 2'd0))
    else $error("opening record malformed");

  a_vtx: assert property (@(posedge clk) disable iff (rst)
    out_valid && (record_kind == vbqt_pkg::REC_VERTEX) |-> !last_of_run)
    else $error("vertex record ends a run");

  a_rst: assert property (@(posedge clk) !rst && $past(rst) |-> !out_valid)
    else $error("record valid after reset");

endmodule

bind voxel_boundary_quad_tessellator vbqt_checker u_vbqt_checker (.*);
